// ===== hw/rtl/greedy_superstring_length_core_macros.svh =====
// Assertion macros shared by the greedy superstring length core.
`ifndef GREEDY_SUPERSTRING_LENGTH_CORE_MACROS_SVH
`define GREEDY_SUPERSTRING_LENGTH_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define GSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("greedy superstring core: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define GSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("greedy superstring core: next-cycle check failed");
`else
`define GSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/gsl_pkg.sv =====
// Types and constants shared by the greedy superstring length core.
package gsl_pkg;

    // Output length width and its saturation value.
    localparam int OUT_W = 11;
    localparam logic [OUT_W-1:0] LEN_SAT = 11'd2047;

    // One input word.
    typedef struct packed {
        logic [7:0] character;
        logic       has_char;
        logic       end_of_string;
        logic       end_of_set;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [OUT_W-1:0] superstring_length;
        logic             overflow;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic ij_clr;
        logic ij_adv;
        logic len_sel_j;
        logic latch_la;
        logic set_k;
        logic t_clr;
        logic t_inc;
        logic k_dec;
        logic wr_ovl;
        logic g_init;
        logic g_cmp;
        logic g_pick;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ovf;
        logic lt2;
        logic last_pair;
        logic diag;
        logic k_zero;
        logic chars_eq;
        logic t_last;
        logic pick_last;
    } t_status;

endpackage

// ===== hw/rtl/gsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gsl_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gsl_dp.sv =====
// Datapath: string stores, overlap matrix, counters and result register.
module gsl_dp import gsl_pkg::*; #(
    parameter int MAX_STRINGS = 16,
    parameter int MAX_LEN     = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_word o_out_word
);

    localparam int SW  = $clog2(MAX_STRINGS);
    localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int CW  = $clog2(MAX_STRINGS + 1);
    localparam int TW  = $clog2(MAX_STRINGS * MAX_LEN + 1);
    localparam int EW  = (TW > OUT_W) ? TW : OUT_W;
    localparam int CAW = SW + IW;
    localparam int MAW = 2 * SW;

    // Set state.
    logic [CW-1:0] r_cnt;
    logic [LW-1:0] r_pos;
    logic [TW-1:0] r_total;
    logic [TW-1:0] r_sum;
    logic          r_ovf;

    // Loop state.
    logic [SW-1:0] r_i, r_j, r_bi, r_bj, r_pick;
    logic [LW-1:0] r_la, r_k, r_t, r_best;
    logic          r_row_dead [MAX_STRINGS];
    logic          r_col_dead [MAX_STRINGS];
    t_out_word     r_out;

    logic          full_s, full_c, char_we, closes, len_we;
    logic [LW-1:0] pos_after, pos_a, len_rd, mat_rd, g_val;
    logic [7:0]    ch_a, ch_b;
    logic [CW-1:0] cnt_m1;
    logic [SW-1:0] nm1;
    logic [TW-1:0] diff;
    logic [EW-1:0] diff_e;
    logic [OUT_W-1:0] len_res;

    // Load decode for one accepted word.
    always_comb begin
        full_s    = r_cnt >= CW'(MAX_STRINGS);
        full_c    = r_pos >= LW'(MAX_LEN);
        char_we   = i_cmd.load && i_in_word.has_char && !full_s && !full_c;
        pos_after = char_we ? r_pos + LW'(1) : r_pos;
        closes    = i_cmd.load && (i_in_word.end_of_string || i_in_word.end_of_set);
        len_we    = closes && !full_s;
    end

    assign cnt_m1 = r_cnt - CW'(1);
    assign nm1    = cnt_m1[SW-1:0];
    assign pos_a  = r_la - r_k + r_t;
    assign g_val  = (r_row_dead[r_i] || r_col_dead[r_j]) ? '0 : mat_rd;

    // Result: total minus picks, floored at zero and saturated; zero when the set overflowed.
    always_comb begin
        diff   = (r_sum >= r_total) ? '0 : r_total - r_sum;
        diff_e = EW'(diff);
        if (r_ovf) begin
            len_res = '0;
        end else if (diff_e > EW'(LEN_SAT)) begin
            len_res = LEN_SAT;
        end else begin
            len_res = diff_e[OUT_W-1:0];
        end
    end

    // Set counters, overflow flag and pick sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_cnt   <= '0;
            r_pos   <= '0;
            r_total <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_in_word.has_char && (full_s || full_c)) begin
                    r_ovf <= 1'b1;
                end
                if (char_we) begin
                    r_total <= r_total + TW'(1);
                end
                r_pos <= closes ? '0 : pos_after;
                if (closes) begin
                    if (full_s) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
            end
            if (i_cmd.g_pick) begin
                r_sum <= r_sum + TW'(r_best);
            end
        end
    end

    // Pair walk, overlap search and greedy pick registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ij_clr) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.ij_adv) begin
            if (r_j == nm1) begin
                r_j <= '0;
                r_i <= r_i + SW'(1);
            end else begin
                r_j <= r_j + SW'(1);
            end
        end
        if (i_cmd.latch_la) begin
            r_la <= len_rd;
        end
        if (i_cmd.set_k) begin
            r_k <= (r_la < len_rd) ? r_la : len_rd;
        end else if (i_cmd.k_dec) begin
            r_k <= r_k - LW'(1);
        end
        if (i_cmd.t_clr) begin
            r_t <= '0;
        end else if (i_cmd.t_inc) begin
            r_t <= r_t + LW'(1);
        end
        if (i_cmd.g_init) begin
            r_best <= '0;
            r_pick <= SW'(1);
            for (int n = 0; n < MAX_STRINGS; n++) begin
                r_row_dead[n] <= 1'b0;
                r_col_dead[n] <= 1'b0;
            end
        end else if (i_cmd.g_cmp) begin
            if (g_val > r_best) begin
                r_best <= g_val;
                r_bi   <= r_i;
                r_bj   <= r_j;
            end
        end else if (i_cmd.g_pick) begin
            r_best           <= '0;
            r_pick           <= r_pick + SW'(1);
            r_row_dead[r_bi] <= 1'b1;
            r_col_dead[r_bj] <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_out.superstring_length <= len_res;
            r_out.overflow           <= r_ovf;
        end
    end

    // Two copies of the character store give one character of string i and one of string j per cycle.
    gsl_ram #(.W(8), .D(1 << CAW)) u_char_a (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr ({r_cnt[SW-1:0], r_pos[IW-1:0]}),
        .i_wdata (i_in_word.character),
        .i_raddr ({r_i, pos_a[IW-1:0]}),
        .o_rdata (ch_a)
    );

    gsl_ram #(.W(8), .D(1 << CAW)) u_char_b (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr ({r_cnt[SW-1:0], r_pos[IW-1:0]}),
        .i_wdata (i_in_word.character),
        .i_raddr ({r_j, r_t[IW-1:0]}),
        .o_rdata (ch_b)
    );

    // String length store.
    gsl_ram #(.W(LW), .D(1 << SW)) u_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_cnt[SW-1:0]),
        .i_wdata (pos_after),
        .i_raddr (i_cmd.len_sel_j ? r_j : r_i),
        .o_rdata (len_rd)
    );

    // Overlap matrix, row-major by string index.
    gsl_ram #(.W(LW), .D(1 << MAW)) u_mat (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_ovl),
        .i_waddr ({r_i, r_j}),
        .i_wdata ((r_i == r_j) ? '0 : r_k),
        .i_raddr ({r_i, r_j}),
        .o_rdata (mat_rd)
    );

    // Status back to the controller.
    always_comb begin
        o_status.ovf       = r_ovf;
        o_status.lt2       = r_cnt < CW'(2);
        o_status.last_pair = (r_i == nm1) && (r_j == nm1);
        o_status.diag      = r_i == r_j;
        o_status.k_zero    = r_k == '0;
        o_status.chars_eq  = ch_a == ch_b;
        o_status.t_last    = ({1'b0, r_t} + (LW + 1)'(1)) == {1'b0, r_k};
        o_status.pick_last = r_pick == nm1;
    end

    assign o_out_word = r_out;

endmodule

// ===== hw/rtl/gsl_ctrl.sv =====
// Controller: sequences loading, overlap search, greedy picks and result hand-off.
module gsl_ctrl import gsl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_end_of_set,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD, S_START, S_PAIR, S_LA, S_LB, S_KCHK, S_CRD, S_CCMP,
        S_GINIT, S_GRD, S_GCMP, S_GPICK, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;
    logic   r_out_valid, n_out_valid;
    logic   in_acc, out_free;

    assign in_acc   = i_in_valid && !r_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_end_of_set) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.ij_clr = 1'b1;
                n_state = (i_status.ovf || i_status.lt2) ? S_EMIT : S_PAIR;
            end
            S_PAIR: begin
                if (i_status.diag) begin
                    o_cmd.wr_ovl = 1'b1;
                    if (i_status.last_pair) begin
                        n_state = S_GINIT;
                    end else begin
                        o_cmd.ij_adv = 1'b1;
                    end
                end else begin
                    n_state = S_LA;
                end
            end
            S_LA: begin
                o_cmd.latch_la  = 1'b1;
                o_cmd.len_sel_j = 1'b1;
                n_state = S_LB;
            end
            S_LB: begin
                o_cmd.set_k = 1'b1;
                n_state = S_KCHK;
            end
            S_KCHK: begin
                if (i_status.k_zero) begin
                    o_cmd.wr_ovl = 1'b1;
                    if (i_status.last_pair) begin
                        n_state = S_GINIT;
                    end else begin
                        o_cmd.ij_adv = 1'b1;
                        n_state = S_PAIR;
                    end
                end else begin
                    o_cmd.t_clr = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                n_state = S_CCMP;
            end
            S_CCMP: begin
                if (!i_status.chars_eq) begin
                    o_cmd.k_dec = 1'b1;
                    n_state = S_KCHK;
                end else if (i_status.t_last) begin
                    o_cmd.wr_ovl = 1'b1;
                    if (i_status.last_pair) begin
                        n_state = S_GINIT;
                    end else begin
                        o_cmd.ij_adv = 1'b1;
                        n_state = S_PAIR;
                    end
                end else begin
                    o_cmd.t_inc = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_GINIT: begin
                o_cmd.g_init = 1'b1;
                o_cmd.ij_clr = 1'b1;
                n_state = S_GRD;
            end
            S_GRD: begin
                n_state = S_GCMP;
            end
            S_GCMP: begin
                o_cmd.g_cmp = 1'b1;
                if (i_status.last_pair) begin
                    n_state = S_GPICK;
                end else begin
                    o_cmd.ij_adv = 1'b1;
                    n_state = S_GRD;
                end
            end
            S_GPICK: begin
                o_cmd.g_pick = 1'b1;
                o_cmd.ij_clr = 1'b1;
                n_state = i_status.pick_last ? S_EMIT : S_GRD;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        n_in_stall = n_state != S_LOAD;
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/greedy_superstring_length_core.sv =====
// Top level of the greedy shortest common superstring length core.
//
//  channel | direction | handshake             | word
//  input   | in        | i_in_valid/o_in_stall | i_in_word (t_in_word)
//  result  | out       | o_out_valid/i_out_stall | o_out_word (t_out_word)
//
// Loading accepts one word per cycle. After the end-of-set word the input stalls
// while the overlap matrix is built (diagonal entries are written as zero; for every
// other pair both lengths are read and overlaps are tried from the longest down,
// character by character) and the greedy picks run (each pick scans all n*n entries).
// Reset is synchronous and active low and clears the set state; stores need no clear.
// A finished result waits until the previous result word has been taken.
`include "greedy_superstring_length_core_macros.svh"
module greedy_superstring_length_core import gsl_pkg::*; #(
    parameter int MAX_STRINGS = 16,
    parameter int MAX_LEN     = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_cmd    cmd;
    t_status status;
    logic    in_acc;
    logic    ovf_out;

    gsl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_end_of_set (i_in_word.end_of_set),
        .i_out_stall  (i_out_stall),
        .i_status     (status),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cmd        (cmd)
    );

    gsl_dp #(.MAX_STRINGS(MAX_STRINGS), .MAX_LEN(MAX_LEN)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_word (o_out_word)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign ovf_out = o_out_valid && o_out_word.overflow;

    // The end-of-set word starts the computation and stops input.
    `GSL_ASSERT_NEXT(a_set_end_stalls, i_clk, i_rst_n, in_acc && i_in_word.end_of_set, o_in_stall)
    // Other words keep input open.
    `GSL_ASSERT_NEXT(a_load_stays_open, i_clk, i_rst_n, in_acc && !i_in_word.end_of_set, !o_in_stall)
    // An overflowed set reports zero length.
    `GSL_ASSERT_IMPLY(a_ovf_zero, i_clk, i_rst_n, ovf_out, ~|o_out_word.superstring_length)

endmodule
